[rtl/rbd_pkg.sv]
`default_nettype none

package rbd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_FACTOR_DEF = 16;
  localparam int unsigned SUM_DEPTH_DEF  = 2048;

  // Source height limit, fixed by the 12-bit row position
  localparam int unsigned ROW_LIMIT = 4096;
  localparam int unsigned ROW_W     = $clog2(ROW_LIMIT + 1);

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned POS_W    = 12;

  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned FACTOR_W = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SCALE_FACTOR = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

[rtl/rbd_ifs.sv]
`default_nettype none

interface rbd_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rbd_pkg::CH_W-1:0]  red_in;
  logic [rbd_pkg::CH_W-1:0]  green_in;
  logic [rbd_pkg::CH_W-1:0]  blue_in;
  logic [rbd_pkg::CH_W-1:0]  alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rbd_res_if;
  logic                      valid;
  logic                      ready;
  logic [rbd_pkg::CH_W-1:0]  red_out;
  logic [rbd_pkg::CH_W-1:0]  green_out;
  logic [rbd_pkg::CH_W-1:0]  blue_out;
  logic [rbd_pkg::CH_W-1:0]  alpha_out;
  logic [rbd_pkg::POS_W-1:0] out_col;
  logic [rbd_pkg::POS_W-1:0] out_row;
  logic                      image_done;

  modport source (output valid, red_out, green_out, blue_out, alpha_out,
                  out_col, out_row, image_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                  out_col, out_row, image_done, output ready);
endinterface

interface rbd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbd_pkg::CFG_IDX_W-1:0]  reg_idx;
  logic [rbd_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_idx, wr_data, input ready);
  modport sink   (input valid, reg_idx, wr_data, output ready);
endinterface

`default_nettype wire

[rtl/rgba_box_downsampler_unit.sv]
// RGBA8 box-filter downsampler.
// pix_i takes source pixels in raster order; res_o gives one averaged pixel per
// factor-by-factor block with its output column, row and an end-of-image flag.
// cfg_i writes image width, image height and scale factor; it is always ready
// and every known write restarts the image at pixel (0, 0).
// One pixel is worked on at a time. A pixel that closes no block passes a
// line-store read, then a read-modify-write. A pixel that closes a block
// passes read, accumulate, 8 steps of the shared restoring divider
// (one quotient bit per step, all four channels in parallel), output load.
// The result goes to res_o through the output register.
// Running column sums live in a single-port-write, one-read synchronous line
// store; each entry is written on a block's first row before it is read, so
// the store has no clearing pass and is usable right after reset.
// Reset clears the position counters and sets width 1, height 1, factor 2.
// When res_o stalls the result is held in the output register; the block keeps
// taking pixels until the next result is ready, then waits for the transfer.
`default_nettype none

module rgba_box_downsampler_unit #(
  parameter int unsigned MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = rbd_pkg::MAX_FACTOR_DEF,
  parameter int unsigned SUM_DEPTH  = rbd_pkg::SUM_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbd_pix_if.sink    pix_i,
  rbd_res_if.source  res_o,
  rbd_cfg_if.sink    cfg_i
);

  localparam int unsigned CHN   = rbd_pkg::CHANNELS;
  localparam int unsigned CHW   = rbd_pkg::CH_W;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SCW   = $clog2(MAX_WIDTH);
  localparam int unsigned FW    = $clog2(MAX_FACTOR + 1);
  localparam int unsigned SBW   = $clog2(MAX_FACTOR);
  localparam int unsigned NW    = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int unsigned DW    = NW + CHW;
  localparam int unsigned SW    = $clog2(MAX_FACTOR * MAX_FACTOR * ((1 << CHW) - 1) + 1);
  localparam int unsigned AW    = $clog2(SUM_DEPTH);
  localparam int unsigned RW    = rbd_pkg::ROW_W;
  localparam int unsigned PW    = rbd_pkg::POS_W;
  localparam int unsigned CNT_W = $clog2(CHW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

  // Configuration registers
  logic [rbd_pkg::SIZE_W-1:0]   width_q, height_q;
  logic [rbd_pkg::FACTOR_W-1:0] factor_q;
  logic                         cfg_wr, cfg_restart;

  // Clamped geometry
  logic [WW-1:0] w;
  logic [RW-1:0] h;
  logic [FW-1:0] f, bw, bh;
  logic          w_lt_f, h_lt_f;

  // Position counters
  logic [SCW-1:0] src_col_q, src_col_d, blk_col_q, blk_col_d;
  logic [PW-1:0]  src_row_q, src_row_d, blk_row_q, blk_row_d;
  logic [SBW-1:0] sub_col_q, sub_col_d, sub_row_q, sub_row_d;
  logic [WW-1:0]  col_base_q, col_base_d;
  logic [RW-1:0]  row_base_q, row_base_d;

  logic sub_col_wrap, sub_row_wrap, col_end, row_end;
  logic col_in, row_in, col_last, row_last, blk_end, fresh, stored;
  logic accept;

  // Per-pixel work registers
  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CHW-1:0]    px_q [CHN];
  logic              fresh_q, stored_q, act_q, hit_q, done_q;
  logic [AW-1:0]     addr_q;
  logic [NW-1:0]     n_q;
  logic [PW-1:0]     ocol_q, orow_q;

  // Line store
  logic [CHN*SW-1:0] mem [SUM_DEPTH];
  logic [CHN*SW-1:0] rd_q, wr_data;
  logic              wr_en;
  logic [SW-1:0]     sum [CHN];

  // Divider
  logic [DW-1:0]  rem_q [CHN];
  logic [DW-1:0]  dvs_q;
  logic [CHW-1:0] quo_q [CHN];
  logic [CHN-1:0] ge;

  // Output register
  logic            res_valid_q;
  logic [CHW-1:0]  res_px_q [CHN];
  logic [PW-1:0]   res_col_q, res_row_q;
  logic            res_done_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign cfg_restart = cfg_wr && (cfg_i.reg_idx == rbd_pkg::REG_IMAGE_WIDTH ||
                                  cfg_i.reg_idx == rbd_pkg::REG_IMAGE_HEIGHT ||
                                  cfg_i.reg_idx == rbd_pkg::REG_SCALE_FACTOR);

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    if (width_q == '0) begin
      w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_q);
    end
    if (height_q == '0) begin
      h = RW'(1);
    end else if (32'(height_q) > rbd_pkg::ROW_LIMIT) begin
      h = RW'(rbd_pkg::ROW_LIMIT);
    end else begin
      h = RW'(height_q);
    end
    if (factor_q == '0) begin
      f = FW'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      f = FW'(MAX_FACTOR);
    end else begin
      f = FW'(factor_q);
    end
  end

  assign w_lt_f = 32'(w) < 32'(f);
  assign h_lt_f = 32'(h) < 32'(f);
  assign bw     = w_lt_f ? FW'(w) : f;
  assign bh     = h_lt_f ? FW'(h) : f;

  // A column is inside a whole block when that block ends at or before the
  // image edge; a narrow image forms one block of what exists.
  assign col_in   = w_lt_f || (32'(col_base_q) + 32'(f) <= 32'(w));
  assign row_in   = h_lt_f || (32'(row_base_q) + 32'(f) <= 32'(h));
  assign col_last = w_lt_f || (32'(col_base_q) + 2 * 32'(f) > 32'(w));
  assign row_last = h_lt_f || (32'(row_base_q) + 2 * 32'(f) > 32'(h));
  assign blk_end  = (32'(sub_col_q) + 1 == 32'(bw)) && (32'(sub_row_q) + 1 == 32'(bh));
  assign fresh    = (sub_col_q == '0) && (sub_row_q == '0);
  assign stored   = 32'(blk_col_q) < SUM_DEPTH;

  assign sub_col_wrap = 32'(sub_col_q) + 1 >= 32'(f);
  assign sub_row_wrap = 32'(sub_row_q) + 1 >= 32'(f);
  assign col_end      = 32'(src_col_q) + 1 >= 32'(w);
  assign row_end      = 32'(src_row_q) + 1 >= 32'(h);

  always_comb begin
    src_col_d  = src_col_q + SCW'(1);
    sub_col_d  = sub_col_q + SBW'(1);
    blk_col_d  = blk_col_q;
    col_base_d = col_base_q;
    src_row_d  = src_row_q;
    sub_row_d  = sub_row_q;
    blk_row_d  = blk_row_q;
    row_base_d = row_base_q;
    if (sub_col_wrap) begin
      sub_col_d  = '0;
      blk_col_d  = blk_col_q + SCW'(1);
      col_base_d = WW'(32'(col_base_q) + 32'(f));
    end
    if (col_end) begin
      src_col_d  = '0;
      sub_col_d  = '0;
      blk_col_d  = '0;
      col_base_d = '0;
      src_row_d  = src_row_q + PW'(1);
      sub_row_d  = sub_row_q + SBW'(1);
      if (sub_row_wrap) begin
        sub_row_d  = '0;
        blk_row_d  = blk_row_q + PW'(1);
        row_base_d = RW'(32'(row_base_q) + 32'(f));
      end
      if (row_end) begin
        src_row_d  = '0;
        sub_row_d  = '0;
        blk_row_d  = '0;
        row_base_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= rbd_pkg::SIZE_W'(1);
      height_q   <= rbd_pkg::SIZE_W'(1);
      factor_q   <= rbd_pkg::FACTOR_W'(2);
      src_col_q  <= '0;
      sub_col_q  <= '0;
      blk_col_q  <= '0;
      col_base_q <= '0;
      src_row_q  <= '0;
      sub_row_q  <= '0;
      blk_row_q  <= '0;
      row_base_q <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_i.reg_idx)
          rbd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_i.wr_data;
          rbd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_i.wr_data;
          rbd_pkg::REG_SCALE_FACTOR: factor_q <= cfg_i.wr_data[rbd_pkg::FACTOR_W-1:0];
          default: ;
        endcase
      end
      if (cfg_restart) begin
        src_col_q  <= '0;
        sub_col_q  <= '0;
        blk_col_q  <= '0;
        col_base_q <= '0;
        src_row_q  <= '0;
        sub_row_q  <= '0;
        blk_row_q  <= '0;
        row_base_q <= '0;
      end else if (accept) begin
        src_col_q  <= src_col_d;
        sub_col_q  <= sub_col_d;
        blk_col_q  <= blk_col_d;
        col_base_q <= col_base_d;
        src_row_q  <= src_row_d;
        sub_row_q  <= sub_row_d;
        blk_row_q  <= blk_row_d;
        row_base_q <= row_base_d;
      end
    end
  end

  // Accumulate: a block's first pixel, or a block column past the line store, starts a fresh sum
  always_comb begin
    for (int c = 0; c < CHN; c++) begin
      sum[c] = ((fresh_q || !stored_q) ? '0 : rd_q[c*SW +: SW]) + SW'(px_q[c]);
      wr_data[c*SW +: SW] = sum[c];
      ge[c] = rem_q[c] >= dvs_q;
    end
  end

  assign wr_en = (state_q == ST_ACC) && act_q && stored_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
    if (accept) begin
      rd_q <= mem[AW'(blk_col_q)];
    end
  end

  // Per-pixel payload, divider datapath and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q[0]  <= pix_i.red_in;
      px_q[1]  <= pix_i.green_in;
      px_q[2]  <= pix_i.blue_in;
      px_q[3]  <= pix_i.alpha_in;
      fresh_q  <= fresh;
      stored_q <= stored;
      act_q    <= col_in && row_in;
      hit_q    <= col_in && row_in && blk_end;
      done_q   <= col_last && row_last;
      addr_q   <= AW'(blk_col_q);
      n_q      <= NW'(bw) * NW'(bh);
      ocol_q   <= PW'(blk_col_q);
      orow_q   <= blk_row_q;
    end
    if (state_q == ST_ACC) begin
      dvs_q <= DW'(n_q) << (CHW - 1);
      for (int c = 0; c < CHN; c++) begin
        rem_q[c] <= DW'(sum[c]);
      end
    end else if (state_q == ST_DIV) begin
      dvs_q <= dvs_q >> 1;
      for (int c = 0; c < CHN; c++) begin
        rem_q[c] <= ge[c] ? rem_q[c] - dvs_q : rem_q[c];
        quo_q[c] <= {quo_q[c][CHW-2:0], ge[c]};
      end
    end
    if (state_q == ST_OUT && (!res_valid_q || res_o.ready)) begin
      for (int c = 0; c < CHN; c++) begin
        res_px_q[c] <= quo_q[c];
      end
      res_col_q  <= ocol_q;
      res_row_q  <= orow_q;
      res_done_q <= done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!res_valid_q || res_o.ready)) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          cnt_q   <= CNT_W'(CHW - 1);
          state_q <= hit_q ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold the quotient until the output register is free
          if (!res_valid_q || res_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.red_out    = res_px_q[0];
  assign res_o.green_out  = res_px_q[1];
  assign res_o.blue_out   = res_px_q[2];
  assign res_o.alpha_out  = res_px_q[3];
  assign res_o.out_col    = res_col_q;
  assign res_o.out_row    = res_row_q;
  assign res_o.image_done = res_done_q;

endmodule

`default_nettype wire

[rtl/rbd_checker.sv]
`default_nettype none

module rbd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      pix_valid_i,
  input wire logic                      pix_ready_i,
  input wire logic                      res_valid_i,
  input wire logic                      res_ready_i,
  input wire logic [rbd_pkg::POS_W-1:0] res_col_i,
  input wire logic [rbd_pkg::POS_W-1:0] res_row_i
);

  // a stalled result keeps its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_col_i) && $stable(res_row_i))
    else $error("stalled result dropped or changed");

  // one pixel in flight: a transfer closes the input until its work is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("pixel taken while previous pixel still in work");

  // a new result only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!pix_ready_i))
    else $error("result appeared without pending work");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("result valid out of reset");

endmodule

bind rgba_box_downsampler_unit rbd_checker u_rbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_col_i   (res_o.out_col),
  .res_row_i   (res_o.out_row)
);

`default_nettype wire
